// ----- hw/rtl/cdgm_pkg.sv -----
// Shared types and constants of the central-difference gradient magnitude block.
`default_nettype none
package cdgm_pkg;

	localparam int PIXEL_W      = 8;
	localparam int GRAD_W       = 9;
	localparam int MAG_W        = 9;
	localparam int BYTE_W       = 8;
	localparam int ROW_IDX_W    = 12;
	localparam int COL_IDX_W    = 10;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;
	localparam int SQ_W         = 17;
	localparam int ROOT_STEPS   = 9;
	localparam int QUEUE_DEPTH  = 4;
	localparam int MIN_DIM      = 3;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int MAG_MAX      = 360;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef struct packed {
		logic emit;
		logic last;
	} tag_t;

endpackage
`default_nettype wire

// ----- hw/rtl/central_difference_gradient_magnitude.sv -----
// Top level of the central-difference gradient magnitude block.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    pixel
//   out      output     out_valid / out_stall  grad_x grad_y magnitude_full magnitude_byte
//                                              row_index column_index frame_last
//   cfg      input      cfg_write              cfg_index cfg_data
//
// A border pixel passes through the front part and the back part but not the square root
// unit; a word is accepted every cycle while the four-word queue has room. An interior pixel
// occupies the square root unit through capture, square, nine root steps and hold, and takes
// no new word until it is idle again. The line buffer needs no clearing pass after reset.
// out_stall holds the result register, which backs up the back part and then the queue.
`default_nettype none
module central_difference_gradient_magnitude #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [cdgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [cdgm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [cdgm_pkg::PIXEL_W-1:0]        pixel,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [cdgm_pkg::GRAD_W-1:0]       grad_x,
	output logic signed [cdgm_pkg::GRAD_W-1:0]       grad_y,
	output logic [cdgm_pkg::MAG_W-1:0]               magnitude_full,
	output logic [cdgm_pkg::BYTE_W-1:0]              magnitude_byte,
	output logic [cdgm_pkg::ROW_IDX_W-1:0]           row_index,
	output logic [cdgm_pkg::COL_IDX_W-1:0]           column_index,
	output logic                                     frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int ITEM_W = cdgm_pkg::PIXEL_W + 2 * CW + cdgm_pkg::ROW_IDX_W
		+ cdgm_pkg::COL_IDX_W + $bits(cdgm_pkg::tag_t);

	logic                               push;
	logic                               full;
	logic [cdgm_pkg::PIXEL_W-1:0]       f_pixel;
	logic [CW-1:0]                      f_waddr;
	logic [CW-1:0]                      f_raddr;
	logic [cdgm_pkg::ROW_IDX_W-1:0]     f_row;
	logic [cdgm_pkg::COL_IDX_W-1:0]     f_col;
	cdgm_pkg::tag_t                     f_tag;
	logic [ITEM_W-1:0]                  q_wdata;
	logic [ITEM_W-1:0]                  q_rdata;
	logic                               q_valid;
	logic                               q_pop;
	logic [cdgm_pkg::PIXEL_W-1:0]       b_pixel;
	logic [CW-1:0]                      b_waddr;
	logic [CW-1:0]                      b_raddr;
	logic [cdgm_pkg::ROW_IDX_W-1:0]     b_row;
	logic [cdgm_pkg::COL_IDX_W-1:0]     b_col;
	cdgm_pkg::tag_t                     b_tag;
	logic                               valid_s1;
	logic                               take;
	logic signed [cdgm_pkg::GRAD_W-1:0] gx_s1;
	logic signed [cdgm_pkg::GRAD_W-1:0] gy_s1;
	logic [cdgm_pkg::ROW_IDX_W-1:0]     row_s1;
	logic [cdgm_pkg::COL_IDX_W-1:0]     col_s1;
	logic                               last_s1;

	assign in_stall = full;
	assign q_wdata  = {f_pixel, f_waddr, f_raddr, f_row, f_col, f_tag};
	assign {b_pixel, b_waddr, b_raddr, b_row, b_col, b_tag} = q_rdata;

	cdgm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.RW         (RW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.full       (full),
		.pixel      (pixel),
		.push       (push),
		.item_pixel (f_pixel),
		.waddr      (f_waddr),
		.raddr      (f_raddr),
		.row_idx    (f_row),
		.col_idx    (f_col),
		.tag        (f_tag)
	);

	cdgm_fifo #(
		.DATA_W (ITEM_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (full),
		.valid  (q_valid),
		.pop    (q_pop),
		.rdata  (q_rdata)
	);

	cdgm_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.pixel    (b_pixel),
		.waddr    (b_waddr),
		.raddr    (b_raddr),
		.row_idx  (b_row),
		.col_idx  (b_col),
		.tag      (b_tag),
		.valid_s1 (valid_s1),
		.take     (take),
		.gx_s1    (gx_s1),
		.gy_s1    (gy_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1),
		.last_s1  (last_s1)
	);

	cdgm_sqrt u_sqrt (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.take           (take),
		.gx_s1          (gx_s1),
		.gy_s1          (gy_s1),
		.row_s1         (row_s1),
		.col_s1         (col_s1),
		.last_s1        (last_s1),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.grad_x         (grad_x),
		.grad_y         (grad_y),
		.magnitude_full (magnitude_full),
		.magnitude_byte (magnitude_byte),
		.row_index      (row_index),
		.column_index   (column_index),
		.frame_last     (frame_last)
	);

`ifndef ASSERT_OFF
	a_pop_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(gx_s1) && $stable(gy_s1))
		else $error("gradient stage lost a word while the root unit was busy");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> magnitude_full <= cdgm_pkg::MAG_W'(cdgm_pkg::MAG_MAX))
		else $error("magnitude out of range");

	a_byte_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (magnitude_byte == ((magnitude_full > 9'd255) ? 8'hFF
			: magnitude_full[7:0])))
		else $error("saturated magnitude does not match full magnitude");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/cdgm_front.sv -----
// Front part: configuration registers, raster counters and classification of each pixel.
`default_nettype none
module cdgm_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int CW         = $clog2(MAX_WIDTH),
	parameter int RW         = $clog2(MAX_HEIGHT)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [cdgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [cdgm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	input  wire logic                               full,
	input  wire logic [cdgm_pkg::PIXEL_W-1:0]       pixel,
	output logic                                    push,
	output logic [cdgm_pkg::PIXEL_W-1:0]            item_pixel,
	output logic [CW-1:0]                           waddr,
	output logic [CW-1:0]                           raddr,
	output logic [cdgm_pkg::ROW_IDX_W-1:0]          row_idx,
	output logic [cdgm_pkg::COL_IDX_W-1:0]          col_idx,
	output cdgm_pkg::tag_t                          tag
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = CW + 1;
	localparam int BW = RW + 1;
	localparam int RST_W = (cdgm_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: cdgm_pkg::RESET_WIDTH;
	localparam int RST_H = (cdgm_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
		: cdgm_pkg::RESET_HEIGHT;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [cdgm_pkg::WIDTH_REG_W-1:0]  wdata;
	logic [cdgm_pkg::HEIGHT_REG_W-1:0] hdata;
	logic [AW-1:0] c_ext, c1, c2, w_ext, nn;
	logic [BW-1:0] r_ext, r1, h_ext;
	logic [RW-1:0] r_dec;

	assign wdata = cfg_data[cdgm_pkg::WIDTH_REG_W-1:0];
	assign hdata = cfg_data[cdgm_pkg::HEIGHT_REG_W-1:0];

	assign push  = in_valid && !full;
	assign c_ext = {1'b0, col_q};
	assign c1    = c_ext + AW'(1);
	assign c2    = c_ext + AW'(2);
	assign w_ext = AW'(width_q);
	assign r_ext = {1'b0, row_q};
	assign r1    = r_ext + BW'(1);
	assign h_ext = BW'(height_q);
	assign nn    = (c2 >= w_ext) ? (c2 - w_ext) : c2;
	assign r_dec = row_q - RW'(1);

	assign item_pixel = pixel;
	assign waddr      = col_q;
	assign raddr      = nn[CW-1:0];
	assign row_idx    = cdgm_pkg::ROW_IDX_W'(r_dec);
	assign col_idx    = cdgm_pkg::COL_IDX_W'(col_q);
	assign tag.emit   = (r_ext >= BW'(2)) && (col_q != '0) && (c1 < w_ext);
	assign tag.last   = (r1 == h_ext) && (c2 == w_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= HW'(RST_H);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write && (cfg_index == cdgm_pkg::REG_IMAGE_WIDTH)) begin
			if (wdata < cdgm_pkg::WIDTH_REG_W'(cdgm_pkg::MIN_DIM)) begin
				width_q <= WW'(cdgm_pkg::MIN_DIM);
			end else if (int'(wdata) > MAX_WIDTH) begin
				width_q <= WW'(MAX_WIDTH);
			end else begin
				width_q <= WW'(wdata);
			end
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write && (cfg_index == cdgm_pkg::REG_IMAGE_HEIGHT)) begin
			if (hdata < cdgm_pkg::HEIGHT_REG_W'(cdgm_pkg::MIN_DIM)) begin
				height_q <= HW'(cdgm_pkg::MIN_DIM);
			end else if (int'(hdata) > MAX_HEIGHT) begin
				height_q <= HW'(MAX_HEIGHT);
			end else begin
				height_q <= HW'(hdata);
			end
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (c1 >= w_ext) begin
				col_q <= '0;
				row_q <= (r1 >= h_ext) ? '0 : r1[RW-1:0];
			end else begin
				col_q <= c1[CW-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cdgm_fifo.sv -----
// Short queue that decouples the front part from the back part.
`default_nettype none
module cdgm_fifo #(
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wdata,
	output logic                   full,
	output logic                   valid,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      rdata
);

	localparam int DEPTH = cdgm_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [NW-1:0]     count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = store_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cdgm_back.sv -----
// Back part: line buffer memory, middle-row taps and the gradient stage.
`default_nettype none
module cdgm_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_valid,
	output logic                                     q_pop,
	input  wire logic [cdgm_pkg::PIXEL_W-1:0]        pixel,
	input  wire logic [CW-1:0]                       waddr,
	input  wire logic [CW-1:0]                       raddr,
	input  wire logic [cdgm_pkg::ROW_IDX_W-1:0]      row_idx,
	input  wire logic [cdgm_pkg::COL_IDX_W-1:0]      col_idx,
	input  wire cdgm_pkg::tag_t                      tag,
	output logic                                     valid_s1,
	input  wire logic                                take,
	output logic signed [cdgm_pkg::GRAD_W-1:0]       gx_s1,
	output logic signed [cdgm_pkg::GRAD_W-1:0]       gy_s1,
	output logic [cdgm_pkg::ROW_IDX_W-1:0]           row_s1,
	output logic [cdgm_pkg::COL_IDX_W-1:0]           col_s1,
	output logic                                     last_s1
);

	localparam int PW = cdgm_pkg::PIXEL_W;

	// Each entry holds the row two back in the upper byte and the previous row in the lower.
	logic [2*PW-1:0] line_q [MAX_WIDTH];
	logic [2*PW-1:0] rd_q;
	logic [2*PW-1:0] tap_c_q;
	logic [2*PW-1:0] tap_l_q;

	logic signed [cdgm_pkg::GRAD_W-1:0] gx;
	logic signed [cdgm_pkg::GRAD_W-1:0] gy;

	assign q_pop = q_valid && (!valid_s1 || take);

	assign gx = $signed({1'b0, tap_l_q[PW-1:0]}) - $signed({1'b0, rd_q[PW-1:0]});
	assign gy = $signed({1'b0, tap_c_q[2*PW-1:PW]}) - $signed({1'b0, pixel});

	always_ff @(posedge clk) begin
		if (q_pop) begin
			line_q[waddr] <= {tap_c_q[PW-1:0], pixel};
			rd_q          <= line_q[raddr];
			tap_c_q       <= rd_q;
			tap_l_q       <= tap_c_q;
			gx_s1         <= gx;
			gy_s1         <= gy;
			row_s1        <= row_idx;
			col_s1        <= col_idx;
			last_s1       <= tag.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop) begin
			valid_s1 <= tag.emit;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cdgm_sqrt.sv -----
// Squaring and bit-pair integer square root unit with the output register.
`default_nettype none
module cdgm_sqrt (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                valid_s1,
	output logic                                     take,
	input  wire logic signed [cdgm_pkg::GRAD_W-1:0]  gx_s1,
	input  wire logic signed [cdgm_pkg::GRAD_W-1:0]  gy_s1,
	input  wire logic [cdgm_pkg::ROW_IDX_W-1:0]      row_s1,
	input  wire logic [cdgm_pkg::COL_IDX_W-1:0]      col_s1,
	input  wire logic                                last_s1,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [cdgm_pkg::GRAD_W-1:0]       grad_x,
	output logic signed [cdgm_pkg::GRAD_W-1:0]       grad_y,
	output logic [cdgm_pkg::MAG_W-1:0]               magnitude_full,
	output logic [cdgm_pkg::BYTE_W-1:0]              magnitude_byte,
	output logic [cdgm_pkg::ROW_IDX_W-1:0]           row_index,
	output logic [cdgm_pkg::COL_IDX_W-1:0]           column_index,
	output logic                                     frame_last
);

	localparam int SW = cdgm_pkg::SQ_W;
	localparam int GW = cdgm_pkg::GRAD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] root_q;
	logic [SW-1:0] bit_q;

	logic signed [2*GW-1:0] gx2;
	logic signed [2*GW-1:0] gy2;
	logic [SW:0]            trial;
	logic                   fits;
	logic [SW-1:0]          root_nx;
	logic [SW-1:0]          rem_nx;

	assign take      = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_HOLD);

	assign gx2     = grad_x * grad_x;
	assign gy2     = grad_y * grad_y;
	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign fits    = ({1'b0, rem_q} >= trial);
	assign root_nx = fits ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign rem_nx  = fits ? (rem_q - trial[SW-1:0]) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rem_q          <= '0;
			root_q         <= '0;
			bit_q          <= '0;
			grad_x         <= '0;
			grad_y         <= '0;
			magnitude_full <= '0;
			magnitude_byte <= '0;
			row_index      <= '0;
			column_index   <= '0;
			frame_last     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (valid_s1) begin
						grad_x       <= gx_s1;
						grad_y       <= gy_s1;
						row_index    <= row_s1;
						column_index <= col_s1;
						frame_last   <= last_s1;
						state_q      <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					rem_q   <= SW'(gx2) + SW'(gy2);
					root_q  <= '0;
					bit_q   <= SW'(1) << (2 * (cdgm_pkg::ROOT_STEPS - 1));
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					rem_q  <= rem_nx;
					root_q <= root_nx;
					bit_q  <= bit_q >> 2;
					if (bit_q[0]) begin
						magnitude_full <= root_nx[cdgm_pkg::MAG_W-1:0];
						magnitude_byte <= (root_nx > SW'(255)) ? '1
							: root_nx[cdgm_pkg::BYTE_W-1:0];
						state_q        <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the central-difference gradient magnitude block.
`default_nettype none
module tb;

	localparam int HALF_PERIOD    = 6;
	localparam int CLK_PERIOD     = 2 * HALF_PERIOD;
	localparam int RESET_CYCLES   = 6;
	localparam int LINE_MAX       = 1024;
	localparam int ROWS_MAX       = 4096;
	localparam int WIDTH_REG_MAX  = 2047;
	localparam int HEIGHT_REG_MAX = 8191;
	localparam int MAX_PAUSE      = 14;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 64;
	localparam int PARTIAL_CAP    = 600;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int EXTREME_CAP    = 300;
	localparam int DIRECTED_ROWS  = 24;
	localparam int TIMEOUT_CYCLES = 3_000_000;

	typedef struct packed {
		logic signed [cdgm_pkg::GRAD_W-1:0] grad_x;
		logic signed [cdgm_pkg::GRAD_W-1:0] grad_y;
		logic [cdgm_pkg::MAG_W-1:0]         magnitude_full;
		logic [cdgm_pkg::BYTE_W-1:0]        magnitude_byte;
		logic [cdgm_pkg::ROW_IDX_W-1:0]     row_index;
		logic [cdgm_pkg::COL_IDX_W-1:0]     column_index;
		logic                               frame_last;
	} gradient_word_t;

	typedef enum logic [1:0] {ROW_PIXEL, ROW_SET_WIDTH, ROW_SET_HEIGHT} row_kind_t;
	typedef enum logic [1:0] {
		STYLE_NOISE, STYLE_EXTREME, STYLE_SMOOTH, STYLE_FLAT
	} pixel_style_t;

	typedef struct {
		row_kind_t      kind;
		int unsigned    value;
		bit             typed;
		gradient_word_t word;
	} directed_row_t;

	localparam gradient_word_t NO_WORD = '0;
	localparam gradient_word_t RISING_CORNER = '{9'sd255, 9'sd255, 9'd360, 8'd255, 12'd1,
		10'd1, 1'b1};
	localparam gradient_word_t FALLING_CORNER = '{-9'sd255, -9'sd255, 9'd360, 8'd255, 12'd1,
		10'd1, 1'b1};

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_write = 1'b0;
	logic [cdgm_pkg::CFG_INDEX_W-1:0]     cfg_index = cdgm_pkg::REG_IMAGE_WIDTH;
	logic [cdgm_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [cdgm_pkg::PIXEL_W-1:0]         pixel = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [cdgm_pkg::GRAD_W-1:0]   grad_x;
	logic signed [cdgm_pkg::GRAD_W-1:0]   grad_y;
	logic [cdgm_pkg::MAG_W-1:0]           magnitude_full;
	logic [cdgm_pkg::BYTE_W-1:0]          magnitude_byte;
	logic [cdgm_pkg::ROW_IDX_W-1:0]       row_index;
	logic [cdgm_pkg::COL_IDX_W-1:0]       column_index;
	logic                                 frame_last;

	bit [cdgm_pkg::PIXEL_W-1:0]           recent_line [LINE_MAX];
	bit [cdgm_pkg::PIXEL_W-1:0]           older_line [LINE_MAX];
	bit [cdgm_pkg::PIXEL_W-1:0]           middle_taps [3];
	int unsigned                          col_pos = 0;
	int unsigned                          row_pos = 0;
	logic [cdgm_pkg::WIDTH_REG_W-1:0]     width_reg =
		cdgm_pkg::WIDTH_REG_W'(cdgm_pkg::RESET_WIDTH);
	logic [cdgm_pkg::HEIGHT_REG_W-1:0]    height_reg =
		cdgm_pkg::HEIGHT_REG_W'(cdgm_pkg::RESET_HEIGHT);

	gradient_word_t          pending_gradients [$];
	bit                      sender_idles = 1'b1;
	bit                      receiver_idles = 1'b1;
	bit                      hold_request = 1'b0;
	int unsigned             mismatches = 0;
	int unsigned             pixels_sent = 0;
	int unsigned             gradients_checked = 0;
	int unsigned             frames_closed = 0;
	int unsigned             register_writes = 0;

	central_difference_gradient_magnitude #(
		.MAX_WIDTH (LINE_MAX),
		.MAX_HEIGHT(ROWS_MAX)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel         (pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.grad_x        (grad_x),
		.grad_y        (grad_y),
		.magnitude_full(magnitude_full),
		.magnitude_byte(magnitude_byte),
		.row_index     (row_index),
		.column_index  (column_index),
		.frame_last    (frame_last)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int unsigned effective_width();
		if (width_reg < cdgm_pkg::MIN_DIM) return cdgm_pkg::MIN_DIM;
		if (width_reg > LINE_MAX) return LINE_MAX;
		return width_reg;
	endfunction

	function automatic int unsigned effective_height();
		if (height_reg < cdgm_pkg::MIN_DIM) return cdgm_pkg::MIN_DIM;
		if (height_reg > ROWS_MAX) return ROWS_MAX;
		return height_reg;
	endfunction

	function automatic int unsigned floor_root(input int unsigned value);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = cdgm_pkg::MAG_W - 1; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= value) root = trial;
		end
		return root;
	endfunction

	// Advances the line buffers and counters by one pixel; returns 1 when an interior
	// gradient word is due.
	function automatic bit gradient_predict(input logic [cdgm_pkg::PIXEL_W-1:0] pix,
		output gradient_word_t word);
		int unsigned                 w;
		int unsigned                 h;
		int unsigned                 here;
		int unsigned                 ahead;
		int unsigned                 root;
		int                          gx;
		int                          gy;
		bit [cdgm_pkg::PIXEL_W-1:0]  above;
		bit                          interior;
		w = effective_width();
		h = effective_height();
		here = col_pos % LINE_MAX;
		ahead = (col_pos + 1) % LINE_MAX;
		above = older_line[here];
		middle_taps[0] = middle_taps[1];
		middle_taps[1] = recent_line[here];
		middle_taps[2] = recent_line[ahead];
		interior = row_pos >= 2 && col_pos >= 1 && col_pos + 1 < w;
		word = NO_WORD;
		if (interior) begin
			gx = int'(middle_taps[0]) - int'(middle_taps[2]);
			gy = int'(above) - int'(pix);
			root = floor_root(gx * gx + gy * gy);
			word.grad_x = cdgm_pkg::GRAD_W'(gx);
			word.grad_y = cdgm_pkg::GRAD_W'(gy);
			word.magnitude_full = cdgm_pkg::MAG_W'(root);
			word.magnitude_byte = (root > 2 ** cdgm_pkg::BYTE_W - 1)
				? {cdgm_pkg::BYTE_W{1'b1}} : cdgm_pkg::BYTE_W'(root);
			word.row_index = cdgm_pkg::ROW_IDX_W'(row_pos - 1);
			word.column_index = cdgm_pkg::COL_IDX_W'(col_pos);
			word.frame_last = (row_pos == h - 1) && (col_pos == w - 2);
		end
		older_line[here] = recent_line[here];
		recent_line[here] = pix;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
		return interior;
	endfunction

	function automatic void compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function automatic int unsigned pick_extent(input int unsigned legal_max,
		input int unsigned reg_max);
		int unsigned choice;
		choice = $urandom_range(0, 9);
		if (choice == 8) return $urandom_range(0, cdgm_pkg::MIN_DIM - 1);
		if (choice == 9) return $urandom_range(legal_max, reg_max);
		return $urandom_range(cdgm_pkg::MIN_DIM, 12);
	endfunction

	function automatic logic [cdgm_pkg::PIXEL_W-1:0] next_pixel(input pixel_style_t style,
		input logic [cdgm_pkg::PIXEL_W-1:0] previous);
		case (style)
			STYLE_EXTREME: return ($urandom_range(0, 1) != 0) ? {cdgm_pkg::PIXEL_W{1'b1}} : '0;
			STYLE_SMOOTH:  return previous + cdgm_pkg::PIXEL_W'($urandom_range(0, 6))
				- cdgm_pkg::PIXEL_W'(3);
			STYLE_FLAT:    return ($urandom_range(0, 15) == 0)
				? cdgm_pkg::PIXEL_W'($urandom) : previous;
			default:       return cdgm_pkg::PIXEL_W'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [cdgm_pkg::PIXEL_W-1:0] value, input bit typed,
		input gradient_word_t typed_word);
		int unsigned    pause;
		bit             due;
		gradient_word_t predicted;
		pause = sender_idles ? $urandom_range(0, MAX_PAUSE) : 0;
		if (pause != 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
		due = gradient_predict(value, predicted);
		if (typed) pending_gradients.push_back(typed_word);
		else if (due) pending_gradients.push_back(predicted);
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_gradients.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [cdgm_pkg::CFG_INDEX_W-1:0] index,
		input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= cdgm_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (index == cdgm_pkg::REG_IMAGE_WIDTH) width_reg = cdgm_pkg::WIDTH_REG_W'(value);
		else height_reg = cdgm_pkg::HEIGHT_REG_W'(value);
		col_pos = 0;
		row_pos = 0;
		register_writes++;
	endtask

	always @(posedge clk) begin : result_check
		gradient_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_gradients.size() == 0) begin
				$display("%0t: gradient word arrived with none expected", $time);
				mismatches++;
			end else begin
				want = pending_gradients.pop_front();
				compare_field("grad_x", want.grad_x, grad_x);
				compare_field("grad_y", want.grad_y, grad_y);
				compare_field("magnitude_full", want.magnitude_full, magnitude_full);
				compare_field("magnitude_byte", want.magnitude_byte, magnitude_byte);
				compare_field("row_index", want.row_index, row_index);
				compare_field("column_index", want.column_index, column_index);
				compare_field("frame_last", want.frame_last, frame_last);
				gradients_checked++;
				frames_closed += frame_last;
			end
		end
	end

	initial begin : receiver
		int unsigned pause;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end
			pause = receiver_idles ? $urandom_range(0, MAX_PAUSE) : 0;
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin : stimulus
		directed_row_t                directed_rows [DIRECTED_ROWS];
		int unsigned                  extreme_width [2];
		int unsigned                  extreme_height [2];
		int unsigned                  random_pixels;
		int unsigned                  phase;
		int unsigned                  total;
		int unsigned                  choice;
		pixel_style_t                 style;
		logic [cdgm_pkg::PIXEL_W-1:0] value;

		// Two 3x3 frames whose single interior word is an extreme corner, then a
		// frame cut short by a register write.
		directed_rows = '{
			'{ROW_SET_WIDTH, 2, 1'b0, NO_WORD},
			'{ROW_SET_HEIGHT, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 255, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 255, 1'b0, NO_WORD},
			'{ROW_PIXEL, 9, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b1, RISING_CORNER},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 7, 1'b0, NO_WORD},
			'{ROW_PIXEL, 255, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_PIXEL, 255, 1'b1, FALLING_CORNER},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_SET_WIDTH, WIDTH_REG_MAX, 1'b0, NO_WORD},
			'{ROW_PIXEL, 255, 1'b0, NO_WORD},
			'{ROW_PIXEL, 0, 1'b0, NO_WORD},
			'{ROW_SET_HEIGHT, HEIGHT_REG_MAX, 1'b0, NO_WORD}
		};
		extreme_width = '{cdgm_pkg::MIN_DIM, WIDTH_REG_MAX};
		extreme_height = '{ROWS_MAX, cdgm_pkg::MIN_DIM};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_SET_WIDTH: begin
					drain_block();
					write_register(cdgm_pkg::REG_IMAGE_WIDTH, directed_rows[i].value);
				end
				ROW_SET_HEIGHT: begin
					drain_block();
					write_register(cdgm_pkg::REG_IMAGE_HEIGHT, directed_rows[i].value);
				end
				default: send_pixel(cdgm_pkg::PIXEL_W'(directed_rows[i].value),
					directed_rows[i].typed, directed_rows[i].word);
			endcase
		end

		random_pixels = 0;
		phase = 0;
		while (random_pixels < RANDOM_ITEMS) begin
			drain_block();
			choice = $urandom_range(0, 3);
			if (choice != 1) write_register(cdgm_pkg::REG_IMAGE_WIDTH,
				pick_extent(LINE_MAX, WIDTH_REG_MAX));
			if (choice != 0) write_register(cdgm_pkg::REG_IMAGE_HEIGHT,
				pick_extent(ROWS_MAX, HEIGHT_REG_MAX));
			sender_idles = $urandom_range(0, 1);
			receiver_idles = $urandom_range(0, 1);
			style = pixel_style_t'($urandom_range(0, 3));
			total = effective_width() * effective_height() * $urandom_range(1, 3);
			if (total > PARTIAL_CAP) total = $urandom_range(1, PARTIAL_CAP);
			else if ($urandom_range(0, 3) == 0) total = $urandom_range(1, total);
			if (phase == 2) begin
				sender_idles = 1'b0;
				hold_request = 1'b1;
			end
			value = cdgm_pkg::PIXEL_W'($urandom);
			repeat (total) begin
				value = next_pixel(style, value);
				send_pixel(value, 1'b0, NO_WORD);
			end
			random_pixels += total;
			phase++;
		end

		// A tall narrow frame under a long receiver hold, then the start of a
		// frame at the widest line.
		foreach (extreme_width[i]) begin
			drain_block();
			write_register(cdgm_pkg::REG_IMAGE_WIDTH, extreme_width[i]);
			write_register(cdgm_pkg::REG_IMAGE_HEIGHT, extreme_height[i]);
			sender_idles = (i != 0);
			receiver_idles = $urandom_range(0, 1);
			if (i == 0) hold_request = 1'b1;
			total = effective_width() * effective_height();
			if (total > EXTREME_CAP) total = EXTREME_CAP;
			repeat (total) send_pixel(cdgm_pkg::PIXEL_W'($urandom), 1'b0, NO_WORD);
		end

		drain_block();
		$display("Sent %0d pixels across %0d register writes; checked %0d gradient words,",
			pixels_sent, register_writes, gradients_checked);
		$display("%0d frame ends; sizes from 3x3 up to 1024 wide and 4096 tall, bad settings too.",
			frames_closed);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("%0t: run did not finish in time", $time);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/cdgm_pkg.sv
hw/rtl/cdgm_front.sv
hw/rtl/cdgm_fifo.sv
hw/rtl/cdgm_back.sv
hw/rtl/cdgm_sqrt.sv
hw/rtl/central_difference_gradient_magnitude.sv
dv/tb.sv
